// ===== rtl/scm_pkg.sv =====
// shared types and constants for the sysex config message decoder
// no dependencies; imported by every module of the block
package scm_pkg;

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END = 8'hF7;
   localparam logic [7:0] CMD_DUMP_REQ = 8'h01;
   localparam logic [7:0] CMD_CONFIG_WR = 8'h03;

   localparam int IdW = 7;
   localparam int IndexW = 6;
   localparam int PosW = 3;
   localparam int SlotW = 3;
   localparam int CsrAddrW = 1;
   localparam int RspDataW = 24;

   localparam logic [PosW-1:0] POS_PAYLOAD = 3'd4;
   localparam logic [SlotW-1:0] SLOT_PREFIX = 3'd0;
   localparam logic [SlotW-1:0] SLOT_LAST = 3'd7;

   localparam logic [CsrAddrW-1:0] CSR_MANUFACTURER_ID = 1'b0;
   localparam logic [CsrAddrW-1:0] CSR_DEVICE_ID = 1'b1;

   localparam logic [IdW-1:0] MANUFACTURER_ID_RESET = 7'd125;
   localparam logic [IdW-1:0] DEVICE_ID_RESET = 7'd3;

   typedef enum logic [2:0] {
      ST_NOT_SYSEX = 3'd0,
      ST_WRONG_ID = 3'd1,
      ST_DUMP_REQ = 3'd2,
      ST_CONFIG_OK = 3'd3,
      ST_WRONG_LEN = 3'd4,
      ST_UNKNOWN_CMD = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic is_last;
   } item_type;

   typedef struct packed {
      logic byte_valid;
      logic [7:0] decoded_byte;
      logic [IndexW-1:0] byte_index;
      logic done_res;
      status_type status;
   } result_type;

endpackage

// ===== rtl/scm_in_stage.sv =====
// input register stage of the sysex config message decoder
// depends on scm_pkg for the item type
module scm_in_stage (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input scm_pkg::item_type req_item,
   output logic stage_valid,
   input logic stage_ready,
   output scm_pkg::item_type stage_item
);
   import scm_pkg::*;

   logic valid_ff;
   item_type item_ff;

   assign req_tready = !valid_ff || stage_ready;
   assign stage_valid = valid_ff;
   assign stage_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/scm_decode.sv =====
// message state, id registers, byte unpacking and result register
// depends on scm_pkg for types, codes and constants
module scm_decode #(
   parameter int CONFIG_BYTES = 64
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input scm_pkg::item_type in_item,
   output logic out_valid,
   input logic out_ready,
   output scm_pkg::result_type out_result,
   input logic csr_we,
   input logic [scm_pkg::CsrAddrW-1:0] csr_addr,
   input logic [scm_pkg::IdW-1:0] csr_wdata
);
   import scm_pkg::*;

   localparam int CntW = $clog2(CONFIG_BYTES + 1);
   localparam logic [CntW-1:0] CntFull = CntW'(CONFIG_BYTES);

   logic [IdW-1:0] manufacturer_id_ff;
   logic [IdW-1:0] device_id_ff;

   logic [PosW-1:0] position_ff, position_in;
   logic start_ok_ff, start_ok_in;
   logic ids_ok_ff, ids_ok_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] prefix_ff, prefix_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [CntW-1:0] count_ff, count_in;

   logic out_valid_ff;
   result_type result_ff, result_in;

   logic take;
   logic [SlotW-1:0] bit_sel;
   logic [CntW+IndexW-1:0] count_wide;

   assign in_ready = !out_valid_ff || out_ready;
   assign take = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_result = result_ff;
   assign bit_sel = slot_ff - SlotW'(1);
   assign count_wide = {{IndexW{1'b0}}, count_ff};

   always_comb begin
      position_in = position_ff;
      start_ok_in = start_ok_ff;
      ids_ok_in = ids_ok_ff;
      command_in = command_ff;
      prefix_in = prefix_ff;
      slot_in = slot_ff;
      count_in = count_ff;
      result_in = '0;
      result_in.status = ST_NOT_SYSEX;
      if (in_item.is_last) begin
         result_in.done_res = 1'b1;
         if (position_ff < POS_PAYLOAD || !start_ok_ff || in_item.in_byte != SYSEX_END) begin
            result_in.status = ST_NOT_SYSEX;
         end else if (!ids_ok_ff) begin
            result_in.status = ST_WRONG_ID;
         end else if (command_ff == CMD_DUMP_REQ) begin
            result_in.status = ST_DUMP_REQ;
         end else if (command_ff == CMD_CONFIG_WR) begin
            result_in.status = (count_ff == CntFull) ? ST_CONFIG_OK : ST_WRONG_LEN;
         end else begin
            result_in.status = ST_UNKNOWN_CMD;
         end
         position_in = '0;
         start_ok_in = 1'b0;
         ids_ok_in = 1'b0;
         command_in = '0;
         prefix_in = '0;
         slot_in = SLOT_PREFIX;
         count_in = '0;
      end else begin
         case (position_ff)
            3'd0: begin
               start_ok_in = (in_item.in_byte == SYSEX_START);
            end
            3'd1: begin
               ids_ok_in = (in_item.in_byte == {1'b0, manufacturer_id_ff});
            end
            3'd2: begin
               ids_ok_in = ids_ok_ff && (in_item.in_byte == {1'b0, device_id_ff});
            end
            3'd3: begin
               command_in = in_item.in_byte;
            end
            default: begin
               if (start_ok_ff && ids_ok_ff && command_ff == CMD_CONFIG_WR
                   && count_ff < CntFull) begin
                  if (slot_ff == SLOT_PREFIX) begin
                     prefix_in = in_item.in_byte;
                     slot_in = SlotW'(1);
                  end else begin
                     result_in.byte_valid = 1'b1;
                     result_in.decoded_byte = in_item.in_byte | {prefix_ff[bit_sel], 7'b0};
                     result_in.byte_index = count_wide[IndexW-1:0];
                     count_in = count_ff + CntW'(1);
                     slot_in = (slot_ff == SLOT_LAST) ? SLOT_PREFIX : slot_ff + SlotW'(1);
                  end
               end
            end
         endcase
         if (position_ff < POS_PAYLOAD) begin
            position_in = position_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manufacturer_id_ff <= MANUFACTURER_ID_RESET;
         device_id_ff <= DEVICE_ID_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MANUFACTURER_ID: manufacturer_id_ff <= csr_wdata;
            CSR_DEVICE_ID: device_id_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         start_ok_ff <= 1'b0;
         ids_ok_ff <= 1'b0;
         command_ff <= '0;
         prefix_ff <= '0;
         slot_ff <= SLOT_PREFIX;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            position_ff <= position_in;
            start_ok_ff <= start_ok_in;
            ids_ok_ff <= ids_ok_in;
            command_ff <= command_in;
            prefix_ff <= prefix_in;
            slot_ff <= slot_in;
            count_ff <= count_in;
         end
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_PAYLOAD)
      else $error("position past payload start");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("unpacked byte count past limit");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      take && in_item.is_last |=> position_ff == '0 && count_ff == '0 && slot_ff == SLOT_PREFIX)
      else $error("message state not cleared after final byte");

   a_byte_not_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.byte_valid |-> !result_ff.done_res)
      else $error("unpacked byte on final item");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !result_ff.done_res |-> result_ff.status == ST_NOT_SYSEX)
      else $error("status set on non-final item");

endmodule

// ===== rtl/sysex_config_message_decoder.sv =====
// top level of the sysex config message decoder
// channel   | dir | signals                               | content
// req       | in  | req_tvalid req_tready req_tdata tlast | one message byte, tlast on final
// rsp       | out | rsp_tvalid rsp_tready rsp_tdata tuser | one result item per input item
// csr       | in  | csr_we csr_addr csr_wdata             | id register writes
// one item in and one result out per cycle when rsp_tready stays high
// each item passes the input register, then the result register
// reset clears message state, valid flags and loads default ids
// a stalled rsp holds its item; req keeps taking items until both registers are full
// depends on scm_pkg, scm_in_stage, scm_decode
module sysex_config_message_decoder #(
   parameter int CONFIG_BYTES = 64
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata,   // [7:0] in_byte
   input logic req_tlast,
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [scm_pkg::RspDataW-1:0] rsp_tdata, // decoded_byte, byte_index, status, zeros
   output logic rsp_tuser,        // byte_valid
   output logic rsp_tlast,
   input logic csr_we,
   input logic [scm_pkg::CsrAddrW-1:0] csr_addr,
   input logic [scm_pkg::IdW-1:0] csr_wdata
);
   import scm_pkg::*;

   item_type req_item;
   item_type stage_item;
   logic stage_valid;
   logic stage_ready;
   result_type result;

   assign req_item.in_byte = req_tdata;
   assign req_item.is_last = req_tlast;

   scm_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_item(req_item),
      .stage_valid(stage_valid),
      .stage_ready(stage_ready),
      .stage_item(stage_item)
   );

   scm_decode #(
      .CONFIG_BYTES(CONFIG_BYTES)
   ) u_decode (
      .clock(clock),
      .reset(reset),
      .in_valid(stage_valid),
      .in_ready(stage_ready),
      .in_item(stage_item),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_result(result),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   assign rsp_tdata = {7'b0, result.status, result.byte_index, result.decoded_byte};
   assign rsp_tuser = result.byte_valid;
   assign rsp_tlast = result.done_res;

endmodule

// ===== test/sysex_config_message_decoder_tb.sv =====
// self-checking testbench for sysex_config_message_decoder: directed table, then random messages
// predicts result items from its own decoder model or the typed directed rows and compares field by field
// depends on scm_pkg and the sysex_config_message_decoder rtl
module sysex_config_message_decoder_tb;
   import scm_pkg::*;

   localparam int CONFIG_BYTES = 64;
   localparam int ITEM_TARGET = 1650;
   localparam int PHASE_ITEMS = 220;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_DIRECTED = 24;

   localparam logic [7:0] MFR_RST_BYTE = {1'b0, MANUFACTURER_ID_RESET};
   localparam logic [7:0] DEV_RST_BYTE = {1'b0, DEVICE_ID_RESET};

   typedef struct packed {
      logic [7:0] in_byte;
      logic is_last;
      logic typed;
      logic byte_valid;
      logic [7:0] decoded_byte;
      logic [IndexW-1:0] byte_index;
      logic done_res;
      logic [2:0] status;
   } directed_row_type;

   // typed rows hold the expected result, the others go through the predictor
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      '{8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 6'd0, 1'b1, ST_NOT_SYSEX},
      // short message with a bad start
      '{8'hF1, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{MFR_RST_BYTE, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{DEV_RST_BYTE, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{SYSEX_END, 1'b1, 1'b1, 1'b0, 8'h00, 6'd0, 1'b1, ST_NOT_SYSEX},
      // dump request
      '{SYSEX_START, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{MFR_RST_BYTE, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{DEV_RST_BYTE, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{CMD_DUMP_REQ, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{SYSEX_END, 1'b1, 1'b1, 1'b0, 8'h00, 6'd0, 1'b1, ST_DUMP_REQ},
      // config write cut short, bit seven restored or kept, end byte as payload
      '{SYSEX_START, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{MFR_RST_BYTE, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{DEV_RST_BYTE, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{CMD_CONFIG_WR, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h80, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{8'h7F, 1'b0, 1'b1, 1'b1, 8'hFF, 6'd1, 1'b0, ST_NOT_SYSEX},
      '{SYSEX_END, 1'b0, 1'b1, 1'b1, 8'hF7, 6'd2, 1'b0, ST_NOT_SYSEX},
      '{SYSEX_END, 1'b1, 1'b1, 1'b0, 8'h00, 6'd0, 1'b1, ST_WRONG_LEN},
      // unknown command
      '{SYSEX_START, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{MFR_RST_BYTE, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{DEV_RST_BYTE, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{8'h7E, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0, ST_NOT_SYSEX},
      '{SYSEX_END, 1'b1, 1'b0, 1'b0, 8'h00, 6'd0, 1'b1, ST_UNKNOWN_CMD}
   };

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_we;
   logic [CsrAddrW-1:0] csr_addr;
   logic [IdW-1:0] csr_wdata;

   sysex_config_message_decoder #(
      .CONFIG_BYTES(CONFIG_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   // decoder model state
   logic [IdW-1:0] cfg_mfr_id;
   logic [IdW-1:0] cfg_dev_id;
   logic [PosW-1:0] msg_pos;
   logic start_seen;
   logic ids_match;
   logic [7:0] cmd_code;
   logic [7:0] unpack_prefix;
   logic [SlotW-1:0] unpack_slot;
   int unpacked_count;

   result_type pending_decodes[$];
   int error_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;
   int cycle_count = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic void clear_message_state();
      msg_pos = '0;
      start_seen = 1'b0;
      ids_match = 1'b0;
      cmd_code = '0;
      unpack_prefix = '0;
      unpack_slot = SLOT_PREFIX;
      unpacked_count = 0;
   endfunction

   function automatic result_type predict_decode(logic [7:0] b, logic last);
      result_type r;
      r = '0;
      r.status = ST_NOT_SYSEX;
      if (last) begin
         r.done_res = 1'b1;
         if (msg_pos < POS_PAYLOAD || !start_seen || b != SYSEX_END)
            r.status = ST_NOT_SYSEX;
         else if (!ids_match)
            r.status = ST_WRONG_ID;
         else if (cmd_code == CMD_DUMP_REQ)
            r.status = ST_DUMP_REQ;
         else if (cmd_code == CMD_CONFIG_WR)
            r.status = (unpacked_count == CONFIG_BYTES) ? ST_CONFIG_OK : ST_WRONG_LEN;
         else
            r.status = ST_UNKNOWN_CMD;
         clear_message_state();
      end else begin
         case (msg_pos)
            3'd0: start_seen = (b == SYSEX_START);
            3'd1: ids_match = (b == {1'b0, cfg_mfr_id});
            3'd2: ids_match = ids_match && (b == {1'b0, cfg_dev_id});
            3'd3: cmd_code = b;
            default: begin
               if (start_seen && ids_match && cmd_code == CMD_CONFIG_WR &&
                   unpacked_count < CONFIG_BYTES) begin
                  if (unpack_slot == SLOT_PREFIX) begin
                     unpack_prefix = b;
                     unpack_slot = 3'd1;
                  end else begin
                     r.byte_valid = 1'b1;
                     r.decoded_byte = {b[7] | unpack_prefix[unpack_slot - 3'd1], b[6:0]};
                     r.byte_index = unpacked_count[IndexW-1:0];
                     unpacked_count++;
                     unpack_slot = (unpack_slot == SLOT_LAST) ? SLOT_PREFIX
                                                                : unpack_slot + 3'd1;
                  end
               end
            end
         endcase
         if (msg_pos < POS_PAYLOAD)
            msg_pos++;
      end
      return r;
   endfunction

   function automatic void report_field(string name, int unsigned expv, int unsigned gotv);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, gotv);
   endfunction

   // result side: random stalls, long hold-off on request, checking
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.byte_valid = rsp_tuser;
         got.decoded_byte = rsp_tdata[7:0];
         got.byte_index = rsp_tdata[13:8];
         got.done_res = rsp_tlast;
         got.status = status_type'(rsp_tdata[16:14]);
         if (pending_decodes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result item, expected none, actual %h",
                     $time, got);
         end else begin
            want = pending_decodes.pop_front();
            if (got.byte_valid !== want.byte_valid)
               report_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            if (got.decoded_byte !== want.decoded_byte)
               report_field("decoded_byte", 32'(want.decoded_byte), 32'(got.decoded_byte));
            if (got.byte_index !== want.byte_index)
               report_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
            if (got.done_res !== want.done_res)
               report_field("done_res", 32'(want.done_res), 32'(got.done_res));
            if (got.status !== want.status)
               report_field("status", 32'(want.status), 32'(got.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sysex_config_message_decoder verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic last, output result_type predicted);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predicted = predict_decode(b, last);
      items_sent++;
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_decodes.size() != 0);
   endtask

   task automatic write_csr(input logic [CsrAddrW-1:0] addr, input logic [IdW-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      if (addr == CSR_MANUFACTURER_ID)
         cfg_mfr_id = value;
      else
         cfg_dev_id = value;
   endtask

   task automatic send_message();
      logic [7:0] msg[$];
      logic [7:0] cmd;
      logic [7:0] mfr_b;
      logic [7:0] dev_b;
      result_type r;
      int kind;
      int n;
      int k;
      mfr_b = {1'b0, cfg_mfr_id};
      dev_b = {1'b0, cfg_dev_id};
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         // config write: exact, short or overflowing payload
         msg = {SYSEX_START, mfr_b, dev_b, CMD_CONFIG_WR};
         case ($urandom_range(0, 2))
            0: n = CONFIG_BYTES;
            1: n = $urandom_range(0, CONFIG_BYTES - 1);
            default: n = CONFIG_BYTES + $urandom_range(1, 20);
         endcase
         for (k = 0; k < n; k++) begin
            if (k % 7 == 0)
               msg.push_back(8'($urandom_range(0, 255)));
            msg.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 3) == 0)
            msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(SYSEX_END);
      end else if (kind < 63) begin
         msg = {SYSEX_START, mfr_b, dev_b, CMD_DUMP_REQ};
         n = $urandom_range(0, 3);
         for (k = 0; k < n; k++)
            msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(SYSEX_END);
      end else if (kind < 71) begin
         do cmd = 8'($urandom_range(0, 255));
         while (cmd == CMD_DUMP_REQ || cmd == CMD_CONFIG_WR);
         msg = {SYSEX_START, mfr_b, dev_b, cmd};
         n = $urandom_range(0, 6);
         for (k = 0; k < n; k++)
            msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(SYSEX_END);
      end else if (kind < 79) begin
         if ($urandom_range(0, 1))
            mfr_b = mfr_b ^ (8'h01 << $urandom_range(0, 7));
         else
            dev_b = dev_b ^ (8'h01 << $urandom_range(0, 7));
         msg = {SYSEX_START, mfr_b, dev_b, $urandom_range(0, 1) ? CMD_CONFIG_WR : CMD_DUMP_REQ};
         n = $urandom_range(0, 10);
         for (k = 0; k < n; k++)
            msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(SYSEX_END);
      end else if (kind < 90) begin
         // bad start, bad end or too short
         msg = {SYSEX_START, mfr_b, dev_b, CMD_CONFIG_WR, 8'h00, 8'h55, SYSEX_END};
         case ($urandom_range(0, 2))
            0: begin
               do msg[0] = 8'($urandom_range(0, 255)); while (msg[0] == SYSEX_START);
            end
            1: begin
               do msg[6] = 8'($urandom_range(0, 255)); while (msg[6] == SYSEX_END);
            end
            default: begin
               n = $urandom_range(1, 4);
               while (msg.size() > n)
                  void'(msg.pop_back());
               msg[n - 1] = $urandom_range(0, 1) ? SYSEX_END : 8'($urandom_range(0, 255));
            end
         endcase
      end else begin
         n = $urandom_range(1, 12);
         for (k = 0; k < n; k++)
            msg.push_back(8'($urandom_range(0, 255)));
      end
      // occasional corruption of any byte but the last, in any kind of message
      if (msg.size() > 1 && $urandom_range(0, 9) == 0)
         msg[$urandom_range(0, msg.size() - 2)] = 8'($urandom_range(0, 255));
      for (k = 0; k < msg.size(); k++) begin
         send_item(msg[k], k == msg.size() - 1, r);
         pending_decodes.push_back(r);
      end
   endtask

   initial begin
      result_type r;
      result_type typed_r;
      int i;
      int phase;
      int phase_end;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = CSR_MANUFACTURER_ID;
      csr_wdata = '0;
      cfg_mfr_id = MANUFACTURER_ID_RESET;
      cfg_dev_id = DEVICE_ID_RESET;
      clear_message_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 22;
      recv_stall_pct = 22;
      for (i = 0; i < NUM_DIRECTED; i++) begin
         send_item(DIRECTED[i].in_byte, DIRECTED[i].is_last, r);
         if (DIRECTED[i].typed) begin
            typed_r.byte_valid = DIRECTED[i].byte_valid;
            typed_r.decoded_byte = DIRECTED[i].decoded_byte;
            typed_r.byte_index = DIRECTED[i].byte_index;
            typed_r.done_res = DIRECTED[i].done_res;
            typed_r.status = status_type'(DIRECTED[i].status);
            pending_decodes.push_back(typed_r);
         end else begin
            pending_decodes.push_back(r);
         end
      end
      wait_all_results();

      for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 73; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 73; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         case (phase % 5)
            0: begin
               write_csr(CSR_MANUFACTURER_ID, '0);
               write_csr(CSR_DEVICE_ID, '1);
            end
            1: begin
               write_csr(CSR_MANUFACTURER_ID, '1);
               write_csr(CSR_DEVICE_ID, '0);
            end
            2: begin
               write_csr(CSR_MANUFACTURER_ID, MANUFACTURER_ID_RESET);
               write_csr(CSR_DEVICE_ID, DEVICE_ID_RESET);
            end
            default: begin
               write_csr(CSR_MANUFACTURER_ID, 7'($urandom_range(0, 127)));
               write_csr(CSR_DEVICE_ID, 7'($urandom_range(0, 127)));
            end
         endcase
         csr_we <= 1'b0;
         if (phase == 0 || phase == 5)
            hold_req++;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end)
            send_message();
         wait_all_results();
      end

      repeat (10) @(posedge clock);
      if (pending_decodes.size() != 0) begin
         error_count++;
         $display("%0t: leftover result items, expected 0, actual %0d",
                  $time, pending_decodes.size());
      end
      if (error_count == 0)
         $display("sysex_config_message_decoder verification clean");
      else
         $display("sysex_config_message_decoder verification failed");
      $finish;
   end

endmodule
